// File: src/bpu_pkg.sv
// Shared types and constants for the BMP pixel unpacker.
// No dependencies; compiled first.

package bpu_pkg;

    localparam int PIX_INDEX_W = 24;
    localparam int RGB_W       = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // supported pixel depths
    localparam logic [5:0] BPP_MONO    = 6'd1;
    localparam logic [5:0] BPP_NIBBLE  = 6'd4;
    localparam logic [5:0] BPP_INDEX8  = 6'd8;
    localparam logic [5:0] BPP_HIGH16  = 6'd16;
    localparam logic [5:0] BPP_TRUE24  = 6'd24;
    localparam logic [5:0] BPP_TRUE32  = 6'd32;

    // register reset values
    localparam logic [5:0]  RST_BPP        = 6'd24;
    localparam logic [12:0] RST_WIDTH      = 13'd1;
    localparam logic [12:0] RST_HEIGHT     = 13'd1;
    localparam logic        RST_TOP_DOWN   = 1'b0;
    localparam logic [15:0] RST_RED_MASK   = 16'h7c00;
    localparam logic [15:0] RST_GREEN_MASK = 16'h03e0;
    localparam logic [15:0] RST_BLUE_MASK  = 16'h001f;

    // 16-bit field scaling
    localparam logic [15:0] GREEN_SIX_MASK = 16'h07e0;
    localparam int          COMP_MAX       = 255;
    localparam int          FULL5          = 31;
    localparam int          FULL6          = 63;

    typedef enum logic [1:0] {
        CMD_PALETTE = 2'd0,
        CMD_PIXEL   = 2'd1,
        CMD_FRAME   = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BPP        = 3'd0,
        REG_WIDTH      = 3'd1,
        REG_HEIGHT     = 3'd2,
        REG_TOP_DOWN   = 3'd3,
        REG_RED_MASK   = 3'd4,
        REG_GREEN_MASK = 3'd5,
        REG_BLUE_MASK  = 3'd6
    } reg_idx_t;

    // where a pixel's color comes from
    typedef enum logic [2:0] {
        SRC_PAL = 3'b001,
        SRC_BGR = 3'b010,
        SRC_FLD = 3'b100
    } src_t;

    typedef struct packed {
        logic [5:0]  bits_per_pixel;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic        top_down;
        logic [15:0] red_mask;
        logic [15:0] green_mask;
        logic [15:0] blue_mask;
    } cfg_t;

    typedef struct packed {
        logic [PIX_INDEX_W-1:0] pixel_index;
        logic [RGB_W-1:0]       raw;
        src_t                   src;
        logic                   last_of_run;
        logic                   frame_done;
    } pix_issue_t;

    typedef struct packed {
        logic             en;
        logic [7:0]       index;
        logic [RGB_W-1:0] rgb;
    } pal_wr_t;

    typedef struct packed {
        logic       en;
        logic [7:0] index;
    } pal_rd_t;

endpackage

// File: src/bpu_if.sv
// Valid/ready channel interfaces for the BMP pixel unpacker.
// Input byte channel and output pixel channel; no package dependency.

interface bpu_byte_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic [7:0] palette_index;
    logic [7:0] palette_red;
    logic [7:0] palette_green;
    logic [7:0] palette_blue;

    modport source (
        output valid, cmd, data_byte, palette_index, palette_red, palette_green,
               palette_blue,
        input  ready
    );
    modport sink (
        input  valid, cmd, data_byte, palette_index, palette_red, palette_green,
               palette_blue,
        output ready
    );
endinterface

interface bpu_pixel_if;
    logic        valid;
    logic        ready;
    logic [23:0] pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last_of_run;
    logic        frame_done;

    modport source (
        output valid, pixel_index, red, green, blue, last_of_run, frame_done,
        input  ready
    );
    modport sink (
        input  valid, pixel_index, red, green, blue, last_of_run, frame_done,
        output ready
    );
endinterface

// File: src/bmp_pixel_unpacker_core.sv
// Top level of the BMP pixel unpacker: configuration registers and block wiring.
// Depends on bpu_pkg, bpu_if, bpu_palette, bpu_sequencer and bpu_color.

// Decodes the pixel array of an uncompressed BMP image, one byte per input
// transaction, into RGB pixels tagged with their raster address. A pixel
// passes the color stage register and then the output register once its
// byte is taken. Depths 8, 16, 24 and 32 take one byte every cycle while
// the output does not stall; depths 1 and 4 hold the input until every
// pixel that the byte yields (up to 8) has issued, because every palette
// pixel needs its own access to the palette memory's one read port. The
// palette reads as black until written; reset clears its valid bits at once,
// so there is no clearing pass. The user writes registers through the plain
// write port only while the block is idle; the block does not enforce this.

module bmp_pixel_unpacker_core #(
    parameter int MAX_WIDTH     = 4096,
    parameter int MAX_HEIGHT    = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bpu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpu_pkg::CFG_DATA_W-1:0] cfg_data,
    bpu_byte_if.sink                       byte_stream,
    bpu_pixel_if.source                    pixel_stream
);
    import bpu_pkg::*;

    cfg_t             cfg_reg, cfg_next;
    logic             can_issue;
    logic             issue_valid;
    pix_issue_t       issue;
    pal_wr_t          pal_wr;
    pal_rd_t          pal_rd;
    logic [RGB_W-1:0] pal_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BPP:        cfg_next.bits_per_pixel = cfg_data[5:0];
                REG_WIDTH:      cfg_next.image_width    = cfg_data[12:0];
                REG_HEIGHT:     cfg_next.image_height   = cfg_data[12:0];
                REG_TOP_DOWN:   cfg_next.top_down       = cfg_data[0];
                REG_RED_MASK:   cfg_next.red_mask       = cfg_data;
                REG_GREEN_MASK: cfg_next.green_mask     = cfg_data;
                REG_BLUE_MASK:  cfg_next.blue_mask      = cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bits_per_pixel <= RST_BPP;
            cfg_reg.image_width    <= RST_WIDTH;
            cfg_reg.image_height   <= RST_HEIGHT;
            cfg_reg.top_down       <= RST_TOP_DOWN;
            cfg_reg.red_mask       <= RST_RED_MASK;
            cfg_reg.green_mask     <= RST_GREEN_MASK;
            cfg_reg.blue_mask      <= RST_BLUE_MASK;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bpu_sequencer #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_sequencer (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .byte_stream (byte_stream),
        .can_issue   (can_issue),
        .issue_valid (issue_valid),
        .issue       (issue),
        .pal_wr      (pal_wr),
        .pal_rd      (pal_rd)
    );

    bpu_palette #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk     (clk),
        .rst_n   (rst_n),
        .pal_wr  (pal_wr),
        .pal_rd  (pal_rd),
        .rd_data (pal_data)
    );

    bpu_color u_color (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .issue_valid  (issue_valid),
        .issue        (issue),
        .pal_data     (pal_data),
        .can_issue    (can_issue),
        .pixel_stream (pixel_stream)
    );

endmodule

// File: src/bpu_palette.sv
// Palette memory: one write port, one synchronous read port, per-entry valid bits.
// Depends on bpu_pkg.

module bpu_palette #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bpu_pkg::pal_wr_t        pal_wr,
    input  bpu_pkg::pal_rd_t        pal_rd,
    output logic [bpu_pkg::RGB_W-1:0] rd_data
);
    import bpu_pkg::*;

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic [RGB_W-1:0]         mem [PALETTE_DEPTH];
    logic [PALETTE_DEPTH-1:0] valid_reg, valid_next;
    logic [RGB_W-1:0]         rd_data_reg;
    logic                     rd_hit_reg, rd_hit_next;
    logic [AW-1:0]            wr_addr, rd_addr;
    logic                     wr_ok, rd_ok;

    assign wr_addr = pal_wr.index[AW-1:0];
    assign rd_addr = pal_rd.index[AW-1:0];
    assign wr_ok   = {1'b0, pal_wr.index} < 9'(PALETTE_DEPTH);
    assign rd_ok   = {1'b0, pal_rd.index} < 9'(PALETTE_DEPTH);

    always_ff @(posedge clk)
    begin
        if (pal_wr.en && wr_ok)
        begin
            mem[wr_addr] <= pal_wr.rgb;
        end
        if (pal_rd.en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        valid_next  = valid_reg;
        rd_hit_next = rd_hit_reg;
        if (pal_wr.en && wr_ok)
        begin
            valid_next[wr_addr] = 1'b1;
        end
        // read data holds while no new read is issued
        if (pal_rd.en)
        begin
            rd_hit_next = rd_ok && valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            rd_hit_reg <= rd_hit_next;
        end
    end

    // never-written and out-of-range entries read as black
    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

// File: src/bpu_sequencer.sv
// Byte sequencer: raster position, row padding, byte assembly, palette access.
// Depends on bpu_pkg and bpu_if.

module bpu_sequencer #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bpu_pkg::cfg_t       cfg,
    bpu_byte_if.sink            byte_stream,
    input  logic                can_issue,
    output logic                issue_valid,
    output bpu_pkg::pix_issue_t issue,
    output bpu_pkg::pal_wr_t    pal_wr,
    output bpu_pkg::pal_rd_t    pal_rd
);
    import bpu_pkg::*;

    localparam int COL_W     = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W     = $clog2(MAX_HEIGHT + 1);
    localparam int RBL_W     = COL_W + 4;
    localparam int RB_W      = COL_W + 6;
    localparam int PROD_W    = COL_W + ROW_W;
    localparam int WORD_BITS = 32;

    localparam logic [ROW_W-1:0] ROW_RST = ROW_W'(RST_TOP_DOWN ? 0 : RST_HEIGHT - 1);
    localparam logic [RBL_W-1:0] RBL_RST =
        RBL_W'(((RST_WIDTH * RST_BPP + WORD_BITS - 1) / WORD_BITS) * (WORD_BITS / 8));
    localparam logic [2:0] MONO_LAST   = 3'(8 / 1 - 1);
    localparam logic [2:0] NIBBLE_LAST = 3'(8 / 4 - 1);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [RBL_W-1:0] rbl_reg, rbl_next;
    logic [1:0]       phase_reg, phase_next;
    logic [23:0]      partial_reg, partial_next;
    logic             finished_reg, finished_next;
    logic             hold_valid_reg, hold_valid_next;
    logic [7:0]       hold_byte_reg, hold_byte_next;
    logic [2:0]       hold_k_reg, hold_k_next;

    logic [COL_W-1:0]  eff_w, col_inc;
    logic [ROW_W-1:0]  eff_h;
    logic [ROW_W:0]    row_plus;
    logic [RB_W-1:0]   row_bits;
    logic [RB_W:0]     row_bits_up;
    logic [RBL_W-1:0]  row_len;
    logic [PROD_W-1:0] row_base;
    logic              last_row, col_lt_w, col_end, done, depth_ok;
    logic              take, step_hold, byte_work, start_frame;
    logic [7:0]        cur_byte, pal_idx;
    logic [2:0]        cur_k;
    logic              emit, run_end, k_last;
    logic [23:0]       raw, merged;
    logic [1:0]        lastphase;
    src_t              src;

    always_comb
    begin
        if (cfg.image_width == '0)
        begin
            eff_w = COL_W'(1);
        end
        else if (32'(cfg.image_width) > MAX_WIDTH)
        begin
            eff_w = COL_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = COL_W'(cfg.image_width);
        end
        if (cfg.image_height == '0)
        begin
            eff_h = ROW_W'(1);
        end
        else if (32'(cfg.image_height) > MAX_HEIGHT)
        begin
            eff_h = ROW_W'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = ROW_W'(cfg.image_height);
        end
    end

    // padded row length in bytes, rounded up to 32-bit words
    assign row_bits    = RB_W'(eff_w) * RB_W'(cfg.bits_per_pixel);
    assign row_bits_up = {1'b0, row_bits} + (RB_W + 1)'(WORD_BITS - 1);
    assign row_len     = RBL_W'({row_bits_up[RB_W:5], 2'b00});

    assign row_plus = {1'b0, row_reg} + 1'b1;
    assign last_row = cfg.top_down ? (row_plus >= {1'b0, eff_h}) : (row_reg == '0);
    assign col_inc  = col_reg + 1'b1;
    assign col_lt_w = col_reg < eff_w;
    assign col_end  = col_inc >= eff_w;
    assign done     = col_end && last_row;
    assign row_base = PROD_W'(row_reg) * PROD_W'(eff_w);

    always_comb
    begin
        unique case (cfg.bits_per_pixel)
            BPP_MONO, BPP_NIBBLE, BPP_INDEX8,
            BPP_HIGH16, BPP_TRUE24, BPP_TRUE32: depth_ok = 1'b1;
            default:                            depth_ok = 1'b0;
        endcase
    end

    // a multi-pixel byte holds the input until its last pixel issues
    assign byte_stream.ready = !hold_valid_reg && can_issue;
    assign take      = byte_stream.valid && byte_stream.ready;
    assign step_hold = hold_valid_reg && can_issue;
    assign cur_byte  = hold_valid_reg ? hold_byte_reg : byte_stream.data_byte;
    assign cur_k     = hold_valid_reg ? hold_k_reg : 3'd0;
    assign lastphase = (cfg.bits_per_pixel == BPP_TRUE24) ? 2'd2 : 2'd3;

    always_comb
    begin
        col_next        = col_reg;
        row_next        = row_reg;
        rbl_next        = rbl_reg;
        phase_next      = phase_reg;
        partial_next    = partial_reg;
        finished_next   = finished_reg;
        hold_valid_next = hold_valid_reg;
        hold_byte_next  = hold_byte_reg;
        hold_k_next     = hold_k_reg;
        byte_work       = 1'b0;
        start_frame     = 1'b0;
        emit            = 1'b0;
        run_end         = 1'b1;
        k_last          = 1'b0;
        raw             = '0;
        merged          = partial_reg;
        src             = SRC_BGR;
        pal_idx         = '0;
        pal_wr.en       = 1'b0;
        pal_wr.index    = byte_stream.palette_index;
        pal_wr.rgb      = {byte_stream.palette_red, byte_stream.palette_green,
                           byte_stream.palette_blue};

        if (step_hold)
        begin
            byte_work = 1'b1;
        end
        else if (take)
        begin
            unique case (byte_stream.cmd)
                CMD_PALETTE: pal_wr.en   = 1'b1;
                CMD_PIXEL:   byte_work   = 1'b1;
                CMD_FRAME:   start_frame = 1'b1;
                default:     ;
            endcase
        end

        if (byte_work)
        begin
            hold_valid_next = 1'b0;
            if (!finished_reg && depth_ok)
            begin
                if (col_lt_w)
                begin
                    unique case (cfg.bits_per_pixel)
                        BPP_MONO, BPP_NIBBLE:
                        begin
                            emit = 1'b1;
                            src  = SRC_PAL;
                            if (cfg.bits_per_pixel == BPP_MONO)
                            begin
                                pal_idx = {7'b0, cur_byte[3'd7 - cur_k]};
                                k_last  = cur_k == MONO_LAST;
                            end
                            else
                            begin
                                pal_idx = (cur_k == 3'd0) ? {4'b0, cur_byte[7:4]}
                                                          : {4'b0, cur_byte[3:0]};
                                k_last  = cur_k == NIBBLE_LAST;
                            end
                            run_end = k_last || col_end;
                            if (!run_end)
                            begin
                                hold_valid_next = 1'b1;
                                hold_byte_next  = cur_byte;
                                hold_k_next     = cur_k + 3'd1;
                            end
                        end
                        BPP_INDEX8:
                        begin
                            emit    = 1'b1;
                            src     = SRC_PAL;
                            pal_idx = cur_byte;
                        end
                        BPP_HIGH16:
                        begin
                            if (phase_reg == 2'd0)
                            begin
                                partial_next = {16'b0, cur_byte};
                                phase_next   = 2'd1;
                            end
                            else
                            begin
                                emit       = 1'b1;
                                src        = SRC_FLD;
                                raw        = {8'b0, cur_byte, partial_reg[7:0]};
                                phase_next = 2'd0;
                            end
                        end
                        default:
                        begin
                            // byte 4 of a 32-bit pixel is alpha and dropped
                            if (phase_reg != 2'd3)
                            begin
                                merged = partial_reg | (24'(cur_byte) << {phase_reg, 3'b000});
                            end
                            if (phase_reg >= lastphase)
                            begin
                                emit         = 1'b1;
                                src          = SRC_BGR;
                                raw          = merged;
                                phase_next   = 2'd0;
                                partial_next = '0;
                            end
                            else
                            begin
                                partial_next = merged;
                                phase_next   = phase_reg + 2'd1;
                            end
                        end
                    endcase
                end

                if (emit)
                begin
                    col_next = col_inc;
                    if (done)
                    begin
                        finished_next = 1'b1;
                    end
                end

                // row byte accounting once the byte's pixels are all out
                if (run_end && !(emit && done))
                begin
                    if (rbl_reg <= RBL_W'(1))
                    begin
                        if (last_row)
                        begin
                            finished_next = 1'b1;
                        end
                        else
                        begin
                            row_next     = cfg.top_down ? row_reg + 1'b1 : row_reg - 1'b1;
                            col_next     = '0;
                            phase_next   = 2'd0;
                            partial_next = '0;
                            rbl_next     = row_len;
                        end
                    end
                    else
                    begin
                        rbl_next = rbl_reg - 1'b1;
                    end
                end
            end
        end

        if (start_frame)
        begin
            col_next      = '0;
            row_next      = cfg.top_down ? '0 : eff_h - 1'b1;
            rbl_next      = row_len;
            phase_next    = 2'd0;
            partial_next  = '0;
            finished_next = 1'b0;
        end
    end

    assign issue_valid       = emit;
    assign issue.pixel_index = 24'(row_base) + 24'(col_reg);
    assign issue.raw         = raw;
    assign issue.src         = src;
    assign issue.last_of_run = emit && run_end;
    assign issue.frame_done  = emit && done;
    assign pal_rd.en         = emit && (src == SRC_PAL);
    assign pal_rd.index      = pal_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= ROW_RST;
            rbl_reg        <= RBL_RST;
            phase_reg      <= 2'd0;
            partial_reg    <= '0;
            finished_reg   <= 1'b0;
            hold_valid_reg <= 1'b0;
            hold_k_reg     <= 3'd0;
        end
        else
        begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            rbl_reg        <= rbl_next;
            phase_reg      <= phase_next;
            partial_reg    <= partial_next;
            finished_reg   <= finished_next;
            hold_valid_reg <= hold_valid_next;
            hold_k_reg     <= hold_k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_byte_reg <= hold_byte_next;
    end

    a_hold_depth: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> (cfg.bits_per_pixel == BPP_MONO ||
                            cfg.bits_per_pixel == BPP_NIBBLE))
        else $error("held byte with a depth that packs one pixel or fewer per byte");

    a_hold_issues: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg && can_issue |-> issue_valid && pal_rd.en)
        else $error("held byte stalled with a free pixel slot");

    a_finished_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> !issue_valid && !hold_valid_reg)
        else $error("pixel issued after the frame completed");

    a_issue_slot: assert property (@(posedge clk) disable iff (!rst_n)
        issue_valid |-> can_issue)
        else $error("pixel issued into a full color stage");

endmodule

// File: src/bpu_color.sv
// Color stage and output register: palette data or bitfield decode, then output.
// Depends on bpu_pkg and bpu_if.

module bpu_color (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bpu_pkg::cfg_t             cfg,
    input  logic                      issue_valid,
    input  bpu_pkg::pix_issue_t       issue,
    input  logic [bpu_pkg::RGB_W-1:0] pal_data,
    output logic                      can_issue,
    bpu_pixel_if.source               pixel_stream
);
    import bpu_pkg::*;

    localparam int SCALE5 = COMP_MAX / FULL5;
    localparam int REM5   = COMP_MAX % FULL5;
    localparam int SCALE6 = COMP_MAX / FULL6;
    localparam int REM6   = COMP_MAX % FULL6;

    // x * 255 / full, saturated: x*SCALE + floor(x*REM/full) below full
    function automatic logic [7:0] field16(input logic [15:0] p, input logic [15:0] mask,
                                           input logic six);
        logic [15:0] lsb;
        logic [15:0] x;
        logic [3:0]  sh;
        logic [7:0]  t;
        logic [2:0]  q;
        logic [7:0]  v;
        lsb = mask & (~mask + 16'd1);
        sh  = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (lsb[i])
            begin
                sh = sh | 4'(i);
            end
        end
        x = (p & mask) >> sh;
        q = '0;
        if (six)
        begin
            t = 8'(x[5:0]) * 8'(REM6);
            for (int k = 1; k < REM6; k++)
            begin
                if (t >= 8'(FULL6 * k))
                begin
                    q = q + 3'd1;
                end
            end
            v = (x >= 16'(FULL6)) ? 8'(COMP_MAX) : 8'(x[5:0]) * 8'(SCALE6) + 8'(q);
        end
        else
        begin
            t = 8'(x[4:0]) * 8'(REM5);
            for (int k = 1; k < REM5; k++)
            begin
                if (t >= 8'(FULL5 * k))
                begin
                    q = q + 3'd1;
                end
            end
            v = (x >= 16'(FULL5)) ? 8'(COMP_MAX) : 8'(x[4:0]) * 8'(SCALE5) + 8'(q);
        end
        return v;
    endfunction

    logic       p_valid_reg, p_valid_next;
    pix_issue_t p_reg;
    logic       out_valid_reg, out_valid_next;
    logic [23:0] idx_reg;
    logic [7:0]  red_reg, green_reg, blue_reg;
    logic        last_reg, done_reg;
    logic [7:0]  red_c, green_c, blue_c;
    logic        p_adv, green_six;

    assign p_adv     = !out_valid_reg || pixel_stream.ready;
    assign can_issue = !p_valid_reg || p_adv;
    assign green_six = cfg.green_mask == GREEN_SIX_MASK;

    always_comb
    begin
        p_valid_next   = issue_valid ? 1'b1 : (p_adv ? 1'b0 : p_valid_reg);
        out_valid_next = p_adv ? p_valid_reg : out_valid_reg;
    end

    always_comb
    begin
        unique case (p_reg.src)
            SRC_PAL:
            begin
                {red_c, green_c, blue_c} = pal_data;
            end
            SRC_FLD:
            begin
                red_c   = field16(p_reg.raw[15:0], cfg.red_mask, 1'b0);
                green_c = field16(p_reg.raw[15:0], cfg.green_mask, green_six);
                blue_c  = field16(p_reg.raw[15:0], cfg.blue_mask, 1'b0);
            end
            default:
            begin
                {red_c, green_c, blue_c} = p_reg.raw;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg   <= p_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_valid)
        begin
            p_reg <= issue;
        end
        if (p_adv && p_valid_reg)
        begin
            idx_reg   <= p_reg.pixel_index;
            red_reg   <= red_c;
            green_reg <= green_c;
            blue_reg  <= blue_c;
            last_reg  <= p_reg.last_of_run;
            done_reg  <= p_reg.frame_done;
        end
    end

    assign pixel_stream.valid       = out_valid_reg;
    assign pixel_stream.pixel_index = idx_reg;
    assign pixel_stream.red         = red_reg;
    assign pixel_stream.green       = green_reg;
    assign pixel_stream.blue        = blue_reg;
    assign pixel_stream.last_of_run = last_reg;
    assign pixel_stream.frame_done  = done_reg;

endmodule

// File: tb/bmp_pixel_unpacker_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for bmp_pixel_unpacker_core: directed and random byte streams,
// checked pixel by pixel against a scoreboard that decodes the same stream.
// Depends on bpu_pkg, bpu_if and the RTL of the unpacker.

module bmp_pixel_unpacker_core_tb;
    import bpu_pkg::*;

    localparam int          MAX_W         = 4096;
    localparam int          MAX_H         = 4096;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          RANDOM_ITEMS  = 250;
    localparam int          CALM_ITEMS    = 200;
    localparam logic [1:0]  CMD_UNUSED    = 2'd3;
    localparam logic [15:0] RED_565       = 16'hf800;
    localparam logic [15:0] BLUE_565      = 16'h001f;

    typedef struct packed {
        logic [23:0] pixel_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last_of_run;
        logic        frame_done;
    } decoded_pixel_t;

    // Decodes the accepted byte stream and holds the pixels still to come out.
    class pixel_tracker;
        logic [5:0]     bpp;
        logic [12:0]    width;
        logic [12:0]    height;
        logic           top_down;
        logic [15:0]    red_mask;
        logic [15:0]    green_mask;
        logic [15:0]    blue_mask;
        logic [23:0]    palette [256];
        int unsigned    col;
        int unsigned    row;
        int unsigned    row_left;
        int unsigned    phase;
        int unsigned    partial;
        bit             finished;
        decoded_pixel_t pending_pixels[$];
        int             errors;

        function new();
            bpp        = RST_BPP;
            width      = RST_WIDTH;
            height     = RST_HEIGHT;
            top_down   = RST_TOP_DOWN;
            red_mask   = RST_RED_MASK;
            green_mask = RST_GREEN_MASK;
            blue_mask  = RST_BLUE_MASK;
            foreach (palette[i])
                palette[i] = '0;
            errors = 0;
            start_frame();
        endfunction

        function int unsigned eff_w();
            int unsigned w;
            w = width;
            if (w == 0)
                w = 1;
            if (w > MAX_W)
                w = MAX_W;
            return w;
        endfunction

        function int unsigned eff_h();
            int unsigned h;
            h = height;
            if (h == 0)
                h = 1;
            if (h > MAX_H)
                h = MAX_H;
            return h;
        endfunction

        function bit depth_ok();
            return bpp == BPP_MONO || bpp == BPP_NIBBLE || bpp == BPP_INDEX8 ||
                   bpp == BPP_HIGH16 || bpp == BPP_TRUE24 || bpp == BPP_TRUE32;
        endfunction

        // padded to 32 bits
        function int unsigned row_length();
            int unsigned bits;
            bits = eff_w() * int'(bpp);
            return ((bits + 31) >> 5) << 2;
        endfunction

        function int unsigned frame_bytes();
            return row_length() * eff_h();
        endfunction

        function bit last_row();
            if (top_down)
                return row + 1 >= eff_h();
            return row == 0;
        endfunction

        function void start_frame();
            col      = 0;
            row      = top_down ? 0 : eff_h() - 1;
            row_left = row_length();
            phase    = 0;
            partial  = 0;
            finished = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [15:0] v);
            case (idx)
                REG_BPP:        bpp        = v[5:0];
                REG_WIDTH:      width      = v[12:0];
                REG_HEIGHT:     height     = v[12:0];
                REG_TOP_DOWN:   top_down   = v[0];
                REG_RED_MASK:   red_mask   = v;
                REG_GREEN_MASK: green_mask = v;
                REG_BLUE_MASK:  blue_mask  = v;
                default: ;
            endcase
        endfunction

        function int unsigned scale_field(int unsigned p, logic [15:0] mask,
                                          int unsigned full);
            int unsigned sh;
            int unsigned v;
            if (mask == 0)
                return 0;
            sh = 0;
            while (mask[sh] == 1'b0)
                sh++;
            v = ((p & mask) >> sh) * COMP_MAX / full;
            return (v > COMP_MAX) ? COMP_MAX : v;
        endfunction

        function bit push_pixel(logic [23:0] rgb);
            decoded_pixel_t p;
            bit done;
            p.pixel_index = 24'(col + row * eff_w());
            p.red         = rgb[23:16];
            p.green       = rgb[15:8];
            p.blue        = rgb[7:0];
            p.last_of_run = 1'b0;
            col++;
            done = col >= eff_w() && last_row();
            p.frame_done = done;
            if (done)
                finished = 1;
            pending_pixels.push_back(p);
            return done;
        endfunction

        function void decode_byte(logic [7:0] data);
            int unsigned w;
            int unsigned depth;
            int unsigned byte_v;
            int unsigned per;
            int unsigned k;
            int unsigned sh;
            int unsigned idx;
            int unsigned n;
            int unsigned last_phase;
            int unsigned p;
            int unsigned g_full;
            int unsigned r;
            int unsigned g;
            int unsigned b;
            w      = eff_w();
            depth  = bpp;
            byte_v = data;
            n      = 0;
            if (finished || !depth_ok())
                return;
            if (col < w) begin
                if (bpp == BPP_MONO || bpp == BPP_NIBBLE) begin
                    per = 8 / depth;
                    for (k = 0; k < per && col < w; k++) begin
                        sh  = 8 - depth * (k + 1);
                        idx = (byte_v >> sh) & ((1 << depth) - 1);
                        n++;
                        if (push_pixel(palette[idx]))
                            break;
                    end
                end else if (bpp == BPP_INDEX8) begin
                    void'(push_pixel(palette[byte_v]));
                    n++;
                end else if (bpp == BPP_HIGH16) begin
                    if (phase == 0) begin
                        partial = byte_v;
                        phase   = 1;
                    end else begin
                        p      = (byte_v << 8) | (partial & 255);
                        g_full = (green_mask == GREEN_SIX_MASK) ? FULL6 : FULL5;
                        r      = scale_field(p, red_mask, FULL5);
                        g      = scale_field(p, green_mask, g_full);
                        b      = scale_field(p, blue_mask, FULL5);
                        phase  = 0;
                        void'(push_pixel({r[7:0], g[7:0], b[7:0]}));
                        n++;
                    end
                end else begin
                    last_phase = (bpp == BPP_TRUE24) ? 2 : 3;
                    // alpha byte of a 32-bit pixel is dropped
                    if (phase < 3)
                        partial |= (byte_v & 255) << (8 * phase);
                    if (phase >= last_phase) begin
                        b       = partial & 255;
                        g       = (partial >> 8) & 255;
                        r       = (partial >> 16) & 255;
                        phase   = 0;
                        partial = 0;
                        void'(push_pixel({r[7:0], g[7:0], b[7:0]}));
                        n++;
                    end else begin
                        phase++;
                    end
                end
            end

            if (n > 0)
                pending_pixels[pending_pixels.size() - 1].last_of_run = 1'b1;

            if (!finished) begin
                if (row_left <= 1) begin
                    // byte count ran out on the last row: frame ends silently
                    if (last_row()) begin
                        finished = 1;
                    end else begin
                        row      = top_down ? row + 1 : row - 1;
                        col      = 0;
                        phase    = 0;
                        partial  = 0;
                        row_left = row_length();
                    end
                end else begin
                    row_left--;
                end
            end
        endfunction

        function void note_item(logic [1:0] cmd, logic [7:0] data, logic [7:0] pidx,
                                logic [7:0] pr, logic [7:0] pg, logic [7:0] pb);
            if (cmd == CMD_PALETTE)
                palette[pidx] = {pr, pg, pb};
            else if (cmd == CMD_PIXEL)
                decode_byte(data);
            else if (cmd == CMD_FRAME)
                start_frame();
        endfunction

        function int pending_count();
            return pending_pixels.size();
        endfunction

        function void check_pixel(decoded_pixel_t got);
            decoded_pixel_t exp_pix;
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel: pixel_index %0d", got.pixel_index);
                errors++;
                return;
            end
            exp_pix = pending_pixels.pop_front();
            if (got.pixel_index !== exp_pix.pixel_index) begin
                $error("pixel_index: expected %0d, got %0d", exp_pix.pixel_index,
                       got.pixel_index);
                errors++;
            end
            if (got.red !== exp_pix.red) begin
                $error("red: expected %0d, got %0d", exp_pix.red, got.red);
                errors++;
            end
            if (got.green !== exp_pix.green) begin
                $error("green: expected %0d, got %0d", exp_pix.green, got.green);
                errors++;
            end
            if (got.blue !== exp_pix.blue) begin
                $error("blue: expected %0d, got %0d", exp_pix.blue, got.blue);
                errors++;
            end
            if (got.last_of_run !== exp_pix.last_of_run) begin
                $error("last_of_run: expected %0d, got %0d", exp_pix.last_of_run,
                       got.last_of_run);
                errors++;
            end
            if (got.frame_done !== exp_pix.frame_done) begin
                $error("frame_done: expected %0d, got %0d", exp_pix.frame_done,
                       got.frame_done);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bpu_byte_if  byte_if ();
    bpu_pixel_if pix_if ();

    pixel_tracker sb;
    bit           idle_on;
    int           random_items;
    int           cycle_count;

    bmp_pixel_unpacker_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .byte_stream  (byte_if),
        .pixel_stream (pix_if)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // output side: random stall bursts while idle_on is set
    initial begin
        pix_if.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 3) == 0) begin
                pix_if.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            pix_if.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        decoded_pixel_t got;
        if (rst_n && pix_if.valid === 1'b1 && pix_if.ready === 1'b1) begin
            got.pixel_index = pix_if.pixel_index;
            got.red         = pix_if.red;
            got.green       = pix_if.green;
            got.blue        = pix_if.blue;
            got.last_of_run = pix_if.last_of_run;
            got.frame_done  = pix_if.frame_done;
            sb.check_pixel(got);
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] data,
                             input logic [7:0] pidx, input logic [7:0] pr,
                             input logic [7:0] pg, input logic [7:0] pb);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            byte_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        byte_if.valid         <= 1'b1;
        byte_if.cmd           <= cmd;
        byte_if.data_byte     <= data;
        byte_if.palette_index <= pidx;
        byte_if.palette_red   <= pr;
        byte_if.palette_green <= pg;
        byte_if.palette_blue  <= pb;
        @(posedge clk);
        while (byte_if.ready !== 1'b1)
            @(posedge clk);
        sb.note_item(cmd, data, pidx, pr, pg, pb);
    endtask

    task automatic send_byte(input logic [7:0] data);
        send_item(CMD_PIXEL, data, 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom));
    endtask

    task automatic send_palette(input logic [7:0] pidx, input logic [7:0] pr,
                                input logic [7:0] pg, input logic [7:0] pb);
        send_item(CMD_PALETTE, 8'($urandom), pidx, pr, pg, pb);
    endtask

    task automatic send_frame_start();
        send_item(CMD_FRAME, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom));
    endtask

    // caller lowers cfg_we after the last write of a batch
    task automatic program_reg(input reg_idx_t idx, input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        sb.write_reg(idx, v);
    endtask

    // padding bytes and palette writes give no pixel, so wait out the pipe too
    task automatic settle();
        byte_if.valid <= 1'b0;
        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_mask(logic [15:0] dflt, logic [15:0] six5);
        case ($urandom_range(0, 5))
            0:       return dflt;
            1:       return six5;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_reg_value(reg_idx_t idx);
        case (idx)
            REG_BPP: begin
                case ($urandom_range(0, 9))
                    8:       return 16'($urandom_range(0, 63));
                    9:       return $urandom_range(0, 1) ? 16'd63 : 16'd0;
                    default: begin
                        case ($urandom_range(0, 5))
                            0:       return 16'(BPP_MONO);
                            1:       return 16'(BPP_NIBBLE);
                            2:       return 16'(BPP_INDEX8);
                            3:       return 16'(BPP_HIGH16);
                            4:       return 16'(BPP_TRUE24);
                            default: return 16'(BPP_TRUE32);
                        endcase
                    end
                endcase
            end
            REG_WIDTH: begin
                case ($urandom_range(0, 19))
                    0, 1:    return 16'd0;
                    2:       return 16'($urandom_range(0, 8191));
                    default: return 16'($urandom_range(1, 12));
                endcase
            end
            REG_HEIGHT: begin
                case ($urandom_range(0, 19))
                    0, 1:    return 16'd0;
                    2:       return 16'($urandom_range(0, 8191));
                    default: return 16'($urandom_range(1, 4));
                endcase
            end
            REG_TOP_DOWN:   return 16'($urandom_range(0, 1));
            REG_RED_MASK:   return pick_mask(RST_RED_MASK, RED_565);
            REG_GREEN_MASK: return pick_mask(RST_GREEN_MASK, GREEN_SIX_MASK);
            default:        return pick_mask(RST_BLUE_MASK, BLUE_565);
        endcase
    endfunction

    task automatic random_phase(input bit write_all);
        int unsigned nbytes;
        int          npal;
        int          i;
        reg_idx_t    idx;
        for (int r = 0; r <= int'(REG_BLUE_MASK); r++) begin
            idx = reg_idx_t'(r);
            if (write_all || $urandom_range(0, 2) == 0)
                program_reg(idx, pick_reg_value(idx));
        end
        cfg_we <= 1'b0;

        // now and then keep the old frame going under the new settings
        if ($urandom_range(0, 7) != 0) begin
            send_frame_start();
            random_items++;
        end

        npal = $urandom_range(0, 4);
        for (i = 0; i < npal; i++) begin
            send_palette($urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom),
                         8'($urandom), 8'($urandom), 8'($urandom));
            random_items++;
        end

        nbytes = sb.frame_bytes();
        if (nbytes == 0 || nbytes > 48)
            nbytes = $urandom_range(4, 40);
        case ($urandom_range(0, 7))
            0:       nbytes += $urandom_range(1, 4);
            1:       nbytes = $urandom_range(1, nbytes);
            default: ;
        endcase

        for (i = 0; i < int'(nbytes); i++) begin
            if ($urandom_range(0, 19) == 0) begin
                case ($urandom_range(0, 2))
                    0: send_item(CMD_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
                                 8'($urandom), 8'($urandom));
                    1: begin
                        send_palette(8'($urandom), 8'($urandom), 8'($urandom),
                                     8'($urandom));
                        random_items++;
                    end
                    default: begin
                        send_frame_start();
                        random_items++;
                    end
                endcase
            end
            send_byte(8'($urandom));
            random_items++;
        end
        settle();
    endtask

    initial begin
        bit first;
        sb                    = new();
        idle_on               = 1'b1;
        random_items          = 0;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        byte_if.valid         = 1'b0;
        byte_if.cmd           = '0;
        byte_if.data_byte     = '0;
        byte_if.palette_index = '0;
        byte_if.palette_red   = '0;
        byte_if.palette_green = '0;
        byte_if.palette_blue  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one 24-bit pixel, one row
        send_palette(8'd0, 8'hff, 8'h00, 8'hff);
        send_palette(8'd255, 8'h00, 8'hff, 8'h00);
        send_palette(8'd1, 8'($urandom), 8'($urandom), 8'($urandom));
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h5a);
        send_byte(8'hc3);   // after frame_done, dropped
        send_item(CMD_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
        settle();

        // 1-bit, 9 pixels per row with padding, two rows top first
        program_reg(REG_BPP, 16'(BPP_MONO));
        program_reg(REG_WIDTH, 16'd9);
        program_reg(REG_HEIGHT, 16'd2);
        program_reg(REG_TOP_DOWN, 16'd1);
        cfg_we <= 1'b0;
        send_frame_start();
        send_byte(8'hff);
        send_byte(8'h80);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h7f);
        send_byte(8'h12);
        send_byte(8'h34);
        settle();

        // 16-bit 5-6-5, full scale and zero
        program_reg(REG_BPP, 16'(BPP_HIGH16));
        program_reg(REG_WIDTH, 16'd2);
        program_reg(REG_HEIGHT, 16'd1);
        program_reg(REG_TOP_DOWN, 16'd0);
        program_reg(REG_RED_MASK, RED_565);
        program_reg(REG_GREEN_MASK, GREEN_SIX_MASK);
        program_reg(REG_BLUE_MASK, BLUE_565);
        cfg_we <= 1'b0;
        send_frame_start();
        send_byte(8'hff);
        send_byte(8'hff);
        send_byte(8'h00);
        send_byte(8'h00);
        settle();

        // oversized width and height saturate; bottom-up gives the top addresses
        program_reg(REG_BPP, 16'(BPP_NIBBLE));
        program_reg(REG_WIDTH, 16'hffff);
        program_reg(REG_HEIGHT, 16'h1fff);
        cfg_we <= 1'b0;
        send_frame_start();
        send_byte(8'h0f);
        send_byte(8'hf0);
        send_byte(8'($urandom));
        settle();

        first = 1'b1;
        while (random_items < RANDOM_ITEMS) begin
            if (random_items >= CALM_ITEMS)
                idle_on = 1'b0;
            random_phase(first);
            first = 1'b0;
        end
        settle();

        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
